[hdl/lph_pkg.sv]
// Shared types, constants and helper functions for the login password hash block.
package lph_pkg;

    // Password length limits and the hash multiplier.
    localparam int unsigned MIN_LEN   = 8;
    localparam int unsigned MAX_LEN   = 40;
    localparam int unsigned POS_W     = $clog2(MAX_LEN + 2);
    localparam logic [31:0] HASH_MULT = 32'h01e3_a1d5;

    // Decimal conversion: ten digit places, digit values up to nine.
    localparam int unsigned NUM_DIGITS = 10;
    localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
    localparam int unsigned DIG_W      = 4;

    // Status codes of a result item.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MUL,
        S_DIGIT,
        S_OUT
    } t_state;

    // Power of ten for one digit place.
    function automatic logic [31:0] pow10(input logic [IDX_W-1:0] idx);
        logic [31:0] p;
        case (idx)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    // Digit to output letter: 0-2 to Q-S, 3-6 to b-e, 7-8 to y-z, 9 stays 9.
    function automatic logic [7:0] map_digit(input logic [DIG_W-1:0] d);
        logic [7:0] c;
        if (d <= 4'd2) begin
            c = 8'(8'h51 + {4'd0, d});
        end else if (d <= 4'd6) begin
            c = 8'(8'h62 + {4'd0, d} - 8'd3);
        end else if (d <= 4'd8) begin
            c = 8'(8'h79 + {4'd0, d} - 8'd7);
        end else begin
            c = 8'h39;
        end
        return c;
    endfunction

endpackage

[hdl/login_password_hash.sv]
// Top level of the login password hash: accumulator, multiplier and digit sequencer.
//
// Usage: the password enters on the input channel one character per item
// (i_pw_char, with i_last_char high on the final one). Each character is
// accepted in the idle state, then in the accumulate state the adder folds
// (char * position) ^ position into the running sum. o_ready is low while
// the sequencer is busy. After the last character, the S_MUL state
// multiplies the sum by the hash constant, then a single compare-and-subtract
// unit walks the ten decimal places from the billions down, one subtraction
// per cycle while no digit waits for the receiver, so a digit d takes d
// subtractions and a leading zero place is not sent. Each digit waits in the
// output register as a result item until i_ready takes it; the block stalls
// as long as the receiver does. A length outside 8 to 40 gives one result
// item with o_status set instead, loaded in the S_MUL state.
// Reset (i_rst_n low at a clock edge) clears the sum, the position count and
// the sequencer, dropping any password in progress.
module login_password_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [7:0]     i_pw_char,
    input  logic                  i_last_char,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_hash_char,
    output logic                  o_last_out,
    output logic                  o_status
);
    import lph_pkg::*;

    t_state               r_state, n_state;
    logic signed [7:0]    r_char;
    logic                 r_last;
    logic [31:0]          r_sum, n_sum;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [31:0]          r_val, n_val;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [DIG_W-1:0]     r_digit, n_digit;
    logic                 r_started, n_started;
    logic [7:0]           r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;
    logic                 r_out_status, n_out_status;

    logic [POS_W-1:0]     pos_inc;
    logic signed [14:0]   prod;
    logic [31:0]          term;
    logic [31:0]          cur_pow;
    logic                 ge;
    logic                 emit;
    logic                 len_ok;

    // Saturating position and the per-character term.
    assign pos_inc = (r_pos < POS_W'(MAX_LEN + 1)) ? POS_W'(r_pos + 1'b1) : r_pos;
    assign prod    = 15'(r_char * $signed({1'b0, pos_inc}));
    assign term    = {{17{prod[14]}}, prod} ^ {{(32-POS_W){1'b0}}, pos_inc};

    // Compare against the current power of ten and decide whether a digit is sent.
    assign cur_pow = pow10(r_idx);
    assign ge      = (r_val >= cur_pow);
    assign emit    = (r_digit != '0) || r_started || (r_idx == '0);
    assign len_ok  = (r_pos >= POS_W'(MIN_LEN)) && (r_pos <= POS_W'(MAX_LEN));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_ACC;
            end
            S_ACC: begin
                n_state = r_last ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                n_state = len_ok ? S_DIGIT : S_OUT;
            end
            S_DIGIT: begin
                if (!ge && emit) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = r_out_last ? S_IDLE : S_DIGIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_sum        = r_sum;
        n_pos        = r_pos;
        n_val        = r_val;
        n_idx        = r_idx;
        n_digit      = r_digit;
        n_started    = r_started;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        case (r_state)
            S_ACC: begin
                n_sum = r_sum + term;
                n_pos = pos_inc;
            end
            S_MUL: begin
                n_val        = r_sum * HASH_MULT;
                n_sum        = '0;
                n_pos        = '0;
                n_idx        = IDX_W'(NUM_DIGITS - 1);
                n_digit      = '0;
                n_started    = 1'b0;
                n_out_char   = 8'h00;
                n_out_last   = 1'b1;
                n_out_status = STATUS_BAD_LEN;
            end
            S_DIGIT: begin
                if (ge) begin
                    n_val   = r_val - cur_pow;
                    n_digit = DIG_W'(r_digit + 1'b1);
                end else if (emit) begin
                    n_out_char   = map_digit(r_digit);
                    n_out_last   = (r_idx == '0);
                    n_out_status = STATUS_OK;
                    n_started    = 1'b1;
                end else begin
                    n_idx = IDX_W'(r_idx - 1'b1);
                end
            end
            S_OUT: begin
                if (i_ready && !r_out_last) begin
                    n_idx   = IDX_W'(r_idx - 1'b1);
                    n_digit = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Handshake outputs; both channels are held off while reset is applied.
    always_comb begin
        o_ready     = i_rst_n && (r_state == S_IDLE);
        o_valid     = i_rst_n && (r_state == S_OUT);
        o_hash_char = r_out_char;
        o_last_out  = r_out_last;
        o_status    = r_out_status;
    end

    // Control and model state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_char <= i_pw_char;
            r_last <= i_last_char;
        end
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_digit      <= n_digit;
        r_started    <= n_started;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

endmodule
